### hdl/arlru_pkg.sv
// Shared types, constants and helpers for the adaptive ref-count LRU block.
// No dependencies; the other files that use it refer to it by scoped names.
package arlru_pkg;

  localparam int Sets   = 1024;
  localparam int Ways   = 8;
  localparam int SetW   = 10;
  localparam int WayW   = 3;
  localparam int CntW   = 24;
  localparam int StampW = 32;
  localparam int RefW   = 8;
  localparam int EntW   = RefW + StampW;
  localparam int RowW   = Ways * EntW;
  localparam int ThrW   = 5;
  localparam int RateW  = 16;
  localparam int DivCntW = 4;

  localparam logic [CntW-1:0]  CntMax   = {CntW{1'b1}};
  localparam logic [CntW-1:0]  WinReset = 24'd10000000;
  localparam logic [RateW-1:0] Rate099  = 16'd64881;
  localparam logic [RateW-1:0] RateMax  = {RateW{1'b1}};
  localparam logic [ThrW-1:0]  ThrCeil  = 5'd22;
  localparam logic [ThrW-1:0]  ThrStep  = 5'd4;
  localparam logic [ThrW-1:0]  ThrInit  = 5'd1;
  localparam logic [RefW-1:0]  RefMax   = {RefW{1'b1}};

  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_INSERT = 2'd1,
    OP_INVAL  = 2'd2,
    OP_VICTIM = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SetW-1:0]   set_idx;
    logic [WayW-1:0]   way;
    logic [StampW-1:0] now;
  } req_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } q_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + CntW'(1);
  endfunction

endpackage

### hdl/arlru_req_if.sv
// Request channel interface: valid/ready plus the request payload.
// Depends on nothing.
interface arlru_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  set_index;
  logic [2:0]  way_index;
  logic [31:0] current_time;

  modport source (output valid, opcode, set_index, way_index, current_time, input ready);
  modport sink   (input valid, opcode, set_index, way_index, current_time, output ready);
endinterface

### hdl/arlru_rsp_if.sv
// Response channel interface: valid/ready plus the result payload.
// Depends on nothing.
interface arlru_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] victim_way;
  logic [4:0] threshold_now;

  modport source (output valid, victim_way, threshold_now, input ready);
  modport sink   (input valid, victim_way, threshold_now, output ready);
endinterface

### hdl/arlru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arlru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/arlru_front.sv
// Front end: accepts request items, decodes the opcode and queues them.
// Depends on arlru_pkg and arlru_req_if.
module arlru_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  arlru_req_if.sink            req_i,
  output arlru_pkg::q_t        q_o,
  input  logic                 pop_i
);

  arlru_pkg::req_t mem_q [2];
  logic            wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  arlru_pkg::req_t in_req;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;

  always_comb begin
    in_req.op      = arlru_pkg::op_e'(req_i.opcode);
    in_req.set_idx = req_i.set_index;
    in_req.way     = req_i.way_index;
    in_req.now     = req_i.current_time;
  end

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_req;
    end
  end

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.req   = mem_q[rptr_q];

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count slip");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue overfilled");

endmodule

### hdl/arlru_back.sv
// Back end: per-set read-modify-write of the count/stamp table, victim scan,
// window counters and the serial miss-rate divider. Depends on arlru_pkg,
// arlru_ram and arlru_rsp_if.
module arlru_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arlru_pkg::CntW-1:0]     cfg_wdata_i,
  input  arlru_pkg::q_t                  q_i,
  output logic                           pop_o,
  arlru_rsp_if.source                    rsp_o
);

  arlru_pkg::state_e state_q, state_d;

  arlru_pkg::req_t                  cur_q, cur_d;
  logic [arlru_pkg::CntW-1:0]       wl_q, wl_d;
  logic [arlru_pkg::CntW-1:0]       acc_q, acc_d, miss_q, miss_d;
  logic [arlru_pkg::ThrW-1:0]       thr_q, thr_d;
  logic                             warm_q, warm_d;
  logic [arlru_pkg::RateW-1:0]      prev_q, prev_d;
  logic [arlru_pkg::SetW-1:0]       clr_q, clr_d;
  logic [arlru_pkg::RowW-1:0]       row_q, row_d;
  logic [arlru_pkg::WayW-1:0]       idx_q, idx_d, best_q, best_d;
  logic [arlru_pkg::StampW-1:0]     bstamp_q, bstamp_d;
  logic [arlru_pkg::CntW-1:0]       rem_q, rem_d;
  logic [arlru_pkg::RateW-1:0]      quo_q, quo_d;
  logic                             sat_q, sat_d;
  logic [arlru_pkg::DivCntW-1:0]    dcnt_q, dcnt_d;
  logic                             rsp_vld_q, rsp_vld_d;
  logic [arlru_pkg::WayW-1:0]       rsp_way_q, rsp_way_d;
  logic [arlru_pkg::ThrW-1:0]       rsp_thr_q, rsp_thr_d;

  logic                             ram_we;
  logic [arlru_pkg::SetW-1:0]       ram_waddr, ram_raddr;
  logic [arlru_pkg::RowW-1:0]       ram_wdata, rdata, row_upd;

  logic                             way_ok, rsp_free, eval;
  logic [arlru_pkg::EntW-1:0]       ent_old, ent_new;
  logic [arlru_pkg::RefW-1:0]       ref_inc;
  logic [arlru_pkg::CntW-1:0]       acc_ins;
  logic                             warm_ins;
  logic [arlru_pkg::CntW:0]         rem2;
  logic                             ge, last;
  logic [arlru_pkg::RateW-1:0]      quo_n, rate;
  logic [arlru_pkg::StampW-1:0]     scan_stamp;

  arlru_ram #(.Width(arlru_pkg::RowW), .Depth(arlru_pkg::Sets)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign rsp_free = !rsp_vld_q || rsp_o.ready;
  assign way_ok   = {1'b0, cur_q.way} < (arlru_pkg::WayW + 1)'(arlru_pkg::Ways);

  // entry update for touch / insert / invalidate
  always_comb begin
    ent_old = rdata[cur_q.way * arlru_pkg::EntW +: arlru_pkg::EntW];
    ref_inc = (ent_old[arlru_pkg::EntW-1 -: arlru_pkg::RefW] == arlru_pkg::RefMax) ?
              arlru_pkg::RefMax : ent_old[arlru_pkg::EntW-1 -: arlru_pkg::RefW] + 8'd1;
    unique case (cur_q.op)
      arlru_pkg::OP_TOUCH: begin
        ent_new = {ref_inc, (ref_inc > {3'b0, thr_q}) ? cur_q.now : 32'd1};
      end
      arlru_pkg::OP_INSERT: ent_new = {8'd1, 32'd1};
      default:              ent_new = '0;
    endcase
    row_upd = rdata;
    row_upd[cur_q.way * arlru_pkg::EntW +: arlru_pkg::EntW] = ent_new;
  end

  // insert: warm-up end or plain count, then window check
  always_comb begin
    if (!warm_q && acc_q > wl_q) begin
      acc_ins  = arlru_pkg::CntW'(1);
      warm_ins = 1'b1;
    end else begin
      acc_ins  = arlru_pkg::sat_inc(acc_q);
      warm_ins = warm_q;
    end
    eval = warm_ins && (acc_ins > wl_q);
  end

  // one quotient bit per cycle; miss < access holds unless saturated
  always_comb begin
    rem2  = {rem_q, 1'b0};
    ge    = rem2 >= {1'b0, acc_q};
    quo_n = {quo_q[arlru_pkg::RateW-2:0], ge};
    last  = dcnt_q == arlru_pkg::DivCntW'(arlru_pkg::RateW - 1);
    rate  = sat_q ? arlru_pkg::RateMax : quo_n;
  end

  assign scan_stamp = row_q[idx_q * arlru_pkg::EntW +: arlru_pkg::StampW];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arlru_pkg::ST_CLEAR: if (clr_q == arlru_pkg::SetW'(arlru_pkg::Sets - 1)) begin
        state_d = arlru_pkg::ST_IDLE;
      end
      arlru_pkg::ST_IDLE: if (q_i.valid) begin
        state_d = arlru_pkg::ST_EXEC;
      end
      arlru_pkg::ST_EXEC: begin
        if (cur_q.op == arlru_pkg::OP_VICTIM && arlru_pkg::Ways > 1) begin
          state_d = arlru_pkg::ST_SCAN;
        end else if (cur_q.op == arlru_pkg::OP_INSERT && eval) begin
          state_d = arlru_pkg::ST_DIV;
        end else begin
          state_d = arlru_pkg::ST_DONE;
        end
      end
      arlru_pkg::ST_SCAN: if (idx_q == arlru_pkg::WayW'(arlru_pkg::Ways - 1)) begin
        state_d = arlru_pkg::ST_DONE;
      end
      arlru_pkg::ST_DIV: if (last) begin
        state_d = arlru_pkg::ST_DONE;
      end
      arlru_pkg::ST_DONE: if (rsp_free) begin
        state_d = arlru_pkg::ST_IDLE;
      end
      default: state_d = arlru_pkg::ST_IDLE;
    endcase
  end

  // outputs: queue pop and RAM port
  always_comb begin
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_q.set_idx;
    ram_wdata = row_upd;
    ram_raddr = q_i.req.set_idx;
    unique case (state_q)
      arlru_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      arlru_pkg::ST_IDLE: pop_o = q_i.valid;
      arlru_pkg::ST_EXEC: ram_we = way_ok && (cur_q.op != arlru_pkg::OP_VICTIM);
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cur_d     = cur_q;
    wl_d      = cfg_we_i ? cfg_wdata_i : wl_q;
    acc_d     = acc_q;
    miss_d    = miss_q;
    thr_d     = thr_q;
    warm_d    = warm_q;
    prev_d    = prev_q;
    clr_d     = clr_q;
    row_d     = row_q;
    idx_d     = idx_q;
    best_d    = best_q;
    bstamp_d  = bstamp_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    sat_d     = sat_q;
    dcnt_d    = dcnt_q;
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    rsp_way_d = rsp_way_q;
    rsp_thr_d = rsp_thr_q;
    unique case (state_q)
      arlru_pkg::ST_CLEAR: clr_d = clr_q + arlru_pkg::SetW'(1);
      arlru_pkg::ST_IDLE: begin
        cur_d  = q_i.req;
        best_d = '0;
      end
      arlru_pkg::ST_EXEC: begin
        unique case (cur_q.op)
          arlru_pkg::OP_TOUCH: acc_d = arlru_pkg::sat_inc(acc_q);
          arlru_pkg::OP_INSERT: begin
            acc_d  = acc_ins;
            warm_d = warm_ins;
            if (!warm_q && warm_ins) begin
              miss_d = '0;
              thr_d  = arlru_pkg::ThrInit;
              prev_d = arlru_pkg::Rate099;
            end
            rem_d  = (!warm_q && warm_ins) ? '0 : miss_q;
            sat_d  = (!warm_q && warm_ins) ? 1'b0 : (miss_q >= acc_ins);
            quo_d  = '0;
            dcnt_d = '0;
          end
          arlru_pkg::OP_INVAL: ;
          arlru_pkg::OP_VICTIM: begin
            miss_d   = arlru_pkg::sat_inc(miss_q);
            row_d    = rdata;
            bstamp_d = rdata[arlru_pkg::StampW-1:0];
            idx_d    = arlru_pkg::WayW'(1);
          end
          default: ;
        endcase
      end
      arlru_pkg::ST_SCAN: begin
        if (scan_stamp < bstamp_q) begin
          best_d   = idx_q;
          bstamp_d = scan_stamp;
        end
        idx_d = idx_q + arlru_pkg::WayW'(1);
      end
      arlru_pkg::ST_DIV: begin
        rem_d  = ge ? arlru_pkg::CntW'(rem2 - {1'b0, acc_q}) : rem2[arlru_pkg::CntW-1:0];
        quo_d  = quo_n;
        dcnt_d = dcnt_q + arlru_pkg::DivCntW'(1);
        if (last) begin
          if (rate < prev_q) begin
            if (thr_q < arlru_pkg::ThrCeil) thr_d = thr_q + arlru_pkg::ThrStep;
          end else if (thr_q > arlru_pkg::ThrInit) begin
            thr_d = thr_q - arlru_pkg::ThrStep;
          end
          prev_d = rate;
          acc_d  = '0;
          miss_d = '0;
        end
      end
      arlru_pkg::ST_DONE: if (rsp_free) begin
        rsp_vld_d = 1'b1;
        rsp_way_d = (cur_q.op == arlru_pkg::OP_VICTIM) ? best_q : '0;
        rsp_thr_d = thr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= arlru_pkg::ST_CLEAR;
      wl_q      <= arlru_pkg::WinReset;
      acc_q     <= '0;
      miss_q    <= '0;
      thr_q     <= arlru_pkg::ThrInit;
      warm_q    <= 1'b0;
      prev_q    <= '0;
      clr_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wl_q      <= wl_d;
      acc_q     <= acc_d;
      miss_q    <= miss_d;
      thr_q     <= thr_d;
      warm_q    <= warm_d;
      prev_q    <= prev_d;
      clr_q     <= clr_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    row_q     <= row_d;
    idx_q     <= idx_d;
    best_q    <= best_d;
    bstamp_q  <= bstamp_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    sat_q     <= sat_d;
    dcnt_q    <= dcnt_d;
    rsp_way_q <= rsp_way_d;
    rsp_thr_q <= rsp_thr_d;
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.victim_way    = rsp_way_q;
  assign rsp_o.threshold_now = rsp_thr_q;

  a_thr_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q[1:0] == 2'b01) else $error("threshold left its step grid");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == arlru_pkg::ST_CLEAR |-> !pop_o) else $error("item taken during clearing");
  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == arlru_pkg::ST_EXEC) else $error("popped item not executed");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == arlru_pkg::ST_DIV |-> acc_q != '0) else $error("divide by zero access count");

endmodule

### hdl/adaptive_refcount_lru_replacement_top.sv
// Top level of the adaptive ref-count LRU replacement block.
// Depends on arlru_pkg, arlru_req_if, arlru_rsp_if, arlru_front, arlru_back.
//
//  channel  | dir | handshake     | payload
//  req_i    | in  | valid / ready | opcode, set_index, way_index, current_time
//  rsp_o    | out | valid / ready | victim_way, threshold_now
//  cfg      | in  | cfg_we_i      | cfg_wdata_i (window_length)
//
// Touch, insert and invalidate run read, write and result in the back end;
// find victim adds the one-way-a-cycle stamp scan.
// An insert that closes a window also runs the serial miss-rate divider.
// After reset a clearing pass zeroes all 1024 sets; items queue meanwhile.
// A two-item queue decouples intake; a held result stalls the back end.
module adaptive_refcount_lru_replacement_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [arlru_pkg::CntW-1:0] cfg_wdata_i,
  arlru_req_if.sink                  req_i,
  arlru_rsp_if.source                rsp_o
);

  arlru_pkg::q_t q;
  logic          pop;

  arlru_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  arlru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_i         (q),
    .pop_o       (pop),
    .rsp_o       (rsp_o)
  );

endmodule

### verif/tb_adaptive_refcount_lru_replacement_top.sv
// Self-checking bench for the adaptive ref-count LRU replacement block.
// Depends on arlru_pkg, arlru_req_if, arlru_rsp_if and the top level.
`timescale 1ns / 1ps

module tb_adaptive_refcount_lru_replacement_top;

  typedef struct packed {
    logic [arlru_pkg::WayW-1:0] victim;
    logic [arlru_pkg::ThrW-1:0] thr;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [arlru_pkg::CntW-1:0] cfg_wdata_i = '0;

  arlru_req_if req_if ();
  arlru_rsp_if rsp_if ();

  adaptive_refcount_lru_replacement_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [arlru_pkg::RefW-1:0]   p_refs   [arlru_pkg::Sets*arlru_pkg::Ways];
  logic [arlru_pkg::StampW-1:0] p_stamps [arlru_pkg::Sets*arlru_pkg::Ways];
  logic [arlru_pkg::CntW-1:0]   p_acc, p_miss, p_window;
  logic [arlru_pkg::ThrW-1:0]   p_thr;
  logic                         p_warm;
  logic [arlru_pkg::RateW-1:0]  p_prev_rate;

  result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap_max = 3;
  int stall_max = 3;

  function automatic void close_window();
    logic [63:0] rate;
    rate = ({40'd0, p_miss} << 16) / {40'd0, p_acc};
    if (rate > 64'hFFFF) rate = 64'hFFFF;
    if (rate[15:0] < p_prev_rate) begin
      if (p_thr < arlru_pkg::ThrCeil) p_thr = p_thr + arlru_pkg::ThrStep;
    end else if (p_thr > 5'd1) begin
      p_thr = p_thr - arlru_pkg::ThrStep;
    end
    p_prev_rate = rate[15:0];
    p_acc = '0;
    p_miss = '0;
  endfunction

  function automatic result_t predict_lru(arlru_pkg::op_e op, logic [arlru_pkg::SetW-1:0] s,
                                          logic [arlru_pkg::WayW-1:0] w,
                                          logic [arlru_pkg::StampW-1:0] now);
    int base;
    int e;
    result_t r;
    base = int'(s) * arlru_pkg::Ways;
    e = base + int'(w);
    r.victim = '0;
    case (op)
      arlru_pkg::OP_TOUCH: begin
        if (p_refs[e] != 8'hFF) p_refs[e] = p_refs[e] + 1'b1;
        p_stamps[e] = ({27'd0, p_thr} < 32'(p_refs[e])) ? now : 32'd1;
        p_acc = arlru_pkg::sat_inc(p_acc);
      end
      arlru_pkg::OP_INSERT: begin
        p_refs[e] = 8'd1;
        p_stamps[e] = 32'd1;
        if (!p_warm && p_acc > p_window) begin
          p_acc = 24'd1;
          p_miss = '0;
          p_thr = 5'd1;
          p_warm = 1'b1;
          p_prev_rate = arlru_pkg::Rate099;
        end else begin
          p_acc = arlru_pkg::sat_inc(p_acc);
        end
        if (p_warm && p_acc > p_window) close_window();
      end
      arlru_pkg::OP_INVAL: begin
        p_refs[e] = '0;
        p_stamps[e] = '0;
      end
      default: begin
        p_miss = arlru_pkg::sat_inc(p_miss);
        for (int k = 1; k < arlru_pkg::Ways; k++)
          if (p_stamps[base + k] < p_stamps[base + int'(r.victim)])
            r.victim = arlru_pkg::WayW'(k);
      end
    endcase
    r.thr = p_thr;
    return r;
  endfunction

  function automatic int rand_gap(int lim);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, lim * 6);
    return $urandom_range(0, lim);
  endfunction

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.set_index = '0;
    req_if.way_index = '0;
    req_if.current_time = '0;
    rsp_if.ready = 1'b0;
  end

  // result side: random stalls, check each accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result victim_way=%0d threshold_now=%0d",
                 rsp_if.victim_way, rsp_if.threshold_now);
          errors++;
        end else begin
          result_t x;
          x = expected_q.pop_front();
          if (rsp_if.victim_way !== x.victim) begin
            $error("victim_way expected %0d got %0d", x.victim, rsp_if.victim_way);
            errors++;
          end
          if (rsp_if.threshold_now !== x.thr) begin
            $error("threshold_now expected %0d got %0d", x.thr, rsp_if.threshold_now);
            errors++;
          end
        end
      end
      rsp_if.ready <= (stall_max == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up between back-to-back items; it drops across a gap, and in drain
  task automatic send_item(arlru_pkg::op_e op, logic [arlru_pkg::SetW-1:0] s,
                           logic [arlru_pkg::WayW-1:0] w, logic [arlru_pkg::StampW-1:0] now);
    int gap;
    gap = rand_gap(send_gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.set_index <= s;
    req_if.way_index <= w;
    req_if.current_time <= now;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_q.push_back(predict_lru(op, s, w, now));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_window(logic [arlru_pkg::CntW-1:0] len);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    p_window = len;
  endtask

  task automatic test_directed();
    send_item(arlru_pkg::OP_VICTIM, 10'd0, 3'd0, 32'd0);
    send_item(arlru_pkg::OP_TOUCH, 10'd1023, 3'd7, 32'hFFFF_FFFF);
    send_item(arlru_pkg::OP_TOUCH, 10'd1023, 3'd7, 32'h0000_0005);
    send_item(arlru_pkg::OP_TOUCH, 10'd1023, 3'd0, 32'h1234_5678);
    send_item(arlru_pkg::OP_VICTIM, 10'd1023, 3'd7, 32'd0);
    send_item(arlru_pkg::OP_INSERT, 10'd1023, 3'd3, 32'hFFFF_FFFF);
    send_item(arlru_pkg::OP_INVAL, 10'd1023, 3'd7, 32'd0);
    send_item(arlru_pkg::OP_VICTIM, 10'd1023, 3'd2, 32'd0);
    send_item(arlru_pkg::OP_INSERT, 10'd0, 3'd0, 32'd0);
    // drive one entry's count past the top to check saturation
    for (int i = 0; i < 260; i++)
      send_item(arlru_pkg::OP_TOUCH, 10'd5, 3'd2, 32'(i + 100));
    send_item(arlru_pkg::OP_VICTIM, 10'd5, 3'd0, 32'd0);
  endtask

  // windows of the given length; small ones let the warm-up and several evaluations happen
  task automatic test_windows(logic [arlru_pkg::CntW-1:0] len, int n);
    logic [arlru_pkg::SetW-1:0] s;
    write_window(len);
    for (int i = 0; i < n; i++) begin
      s = arlru_pkg::SetW'($urandom_range(0, 15));
      send_item(arlru_pkg::op_e'($urandom_range(0, 3)), s, arlru_pkg::WayW'($urandom()),
                $urandom());
    end
  endtask

  task automatic test_random_sets(int n);
    for (int i = 0; i < n; i++)
      send_item(arlru_pkg::op_e'($urandom_range(0, 3)), arlru_pkg::SetW'($urandom()),
                arlru_pkg::WayW'($urandom()), $urandom());
  endtask

  task automatic test_paused_sender();
    drain();
    send_gap_max = 0;
    stall_max = 0;
    test_windows(24'd3, 60);
    send_gap_max = 3;
    stall_max = 3;
  endtask

  initial begin
    for (int i = 0; i < arlru_pkg::Sets * arlru_pkg::Ways; i++) begin
      p_refs[i] = '0;
      p_stamps[i] = '0;
    end
    p_acc = '0;
    p_miss = '0;
    p_thr = arlru_pkg::ThrInit;
    p_warm = 1'b0;
    p_prev_rate = '0;
    p_window = arlru_pkg::WinReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_sets(60);
    test_windows(24'hFFFFFF, 40);
    test_windows(24'd0, 60);
    test_windows(24'd1, 120);
    test_windows(24'd7, 60);
    test_paused_sender();
    test_windows(24'd40, 100);
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
